>>> design/mtep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  // Result kinds carried on the output tuser.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SHORT   = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_END     = 2'd2;
  localparam kind_t KIND_ERROR   = 2'd3;

  // Status bytes with special handling.
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SONG_POS   = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] META_TEMPO    = 8'h51;

  // Packed result width: 161 bits of fields padded to whole bytes.
  localparam int OUT_DATA_W = 168;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] event_len(input logic [7:0] st);
    logic [1:0] len;
    len = 2'd0;
    if (st[7]) begin
      case (st[6:4])
        3'b000, 3'b001, 3'b010, 3'b011, 3'b110: len = 2'd2;
        3'b100, 3'b101: len = 2'd1;
        3'b111: begin
          if (st == ST_SONG_POS) len = 2'd2;
          else if (st == ST_SONG_SEL) len = 2'd1;
          else len = 2'd0;
        end
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

  // Fields of one result item, minus the kind.
  typedef struct packed {
    logic [7:0]  track_index;
    logic [23:0] tempo_us;
    logic        tempo_valid;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic [31:0] event_tick;
    logic [31:0] delta_ticks;
    logic [7:0]  second_data;
    logic [7:0]  first_data;
    logic [7:0]  event_status;
  } result_t;

endpackage

`default_nettype wire

>>> design/midi_track_event_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// MIDI track event parser. One byte of track chunk event data enters per item and
// at most one result item leaves for it, in the cycle after acceptance; a new byte
// can be taken every cycle while no held result waits downstream. All parsing for
// a byte (delta time decode, running status, short event data, sysex and meta
// payload streaming, tempo capture) is done in combinational logic between the
// parse state registers and the output register, whose longest path is the
// 32-bit tick counter add. The output register lets a new byte enter in the cycle
// its result is taken. Set s_axis_tuser with the first byte of each track; tick
// time restarts and the track index advances. cfg_data is the tempo report enable.
module midi_track_event_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] data_byte
  input  wire logic [7:0]                        s_axis_tdata,
  // [0] track_start
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] event_status, [15:8] first_data, [23:16] second_data,
  // [55:24] delta_ticks, [87:56] event_tick, [95:88] payload_byte,
  // [127:96] payload_length, [128] tempo_valid, [152:129] tempo_us,
  // [160:153] track_index, [167:161] zero
  output logic [mtep_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // [1:0] kind
  output mtep_pkg::kind_t                        m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data
);
  import mtep_pkg::*;

  localparam logic [2:0] PH_DELTA    = 3'd0;
  localparam logic [2:0] PH_STATUS   = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_METATYPE = 3'd3;
  localparam logic [2:0] PH_LENGTH   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD  = 3'd5;

  localparam int RES_W = $bits(result_t);

  // Parse state.
  logic        tempo_enable;
  logic [2:0]  phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [31:0] vlq_acc, vlq_acc_next;
  logic [31:0] delta_hold, delta_hold_next;
  logic [31:0] tick_count, tick_count_next;
  logic [7:0]  data_hold, data_hold_next;
  logic [1:0]  bytes_left_short, bytes_left_short_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] payload_total, payload_total_next;
  logic [23:0] tempo_acc, tempo_acc_next;
  logic [1:0]  payload_seen, payload_seen_next;
  logic [7:0]  track_number, track_number_next;

  // Output register.
  result_t     out_res, res;
  kind_t       out_kind, res_kind;
  logic        res_emit;
  logic        accept;
  logic [7:0]  b;
  logic [1:0]  rs_len;
  logic        tv;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign b             = s_axis_tdata;

  // Next state and result for the byte at the input.
  always_comb begin
    track_number_next     = track_number;
    tick_count_next       = tick_count;
    phase_next            = phase;
    vlq_acc_next          = vlq_acc;
    bytes_left_short_next = bytes_left_short;
    payload_left_next     = payload_left;
    payload_seen_next     = payload_seen;
    tempo_acc_next        = tempo_acc;
    running_status_next   = running_status;
    delta_hold_next       = delta_hold;
    data_hold_next        = data_hold;
    meta_kind_next        = meta_kind;
    payload_total_next    = payload_total;
    res_emit              = 1'b0;
    res_kind              = KIND_SHORT;
    res                   = '0;
    rs_len                = event_len(running_status);
    tv                    = 1'b0;

    // A new track restarts timing and the parse phase.
    if (s_axis_tuser) begin
      track_number_next     = track_number + 8'd1;
      tick_count_next       = '0;
      phase_next            = PH_DELTA;
      vlq_acc_next          = '0;
      bytes_left_short_next = '0;
      payload_left_next     = '0;
      payload_seen_next     = '0;
      tempo_acc_next        = '0;
    end

    case (phase_next)
      PH_DELTA: begin
        vlq_acc_next = {vlq_acc_next[24:0], b[6:0]};
        if (!b[7]) begin
          delta_hold_next = vlq_acc_next;
          tick_count_next = tick_count_next + vlq_acc_next;
          vlq_acc_next    = '0;
          phase_next      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          running_status_next = b;
          if (b == ST_META) begin
            phase_next = PH_METATYPE;
          end else if (b inside {ST_SYSEX, ST_SYSEX_CONT}) begin
            meta_kind_next = '0;
            vlq_acc_next   = '0;
            phase_next     = PH_LENGTH;
          end else if (event_len(b) == 2'd0) begin
            phase_next = PH_DELTA;
            res_emit   = 1'b1;
            res_kind   = KIND_SHORT;
          end else begin
            bytes_left_short_next = event_len(b);
            phase_next            = PH_DATA;
          end
        end else if (rs_len == 2'd0) begin
          // Data byte with no usable running status: drop it.
          phase_next     = PH_DELTA;
          res_emit       = 1'b1;
          res_kind       = KIND_ERROR;
          res.first_data = b;
        end else if (rs_len == 2'd1) begin
          phase_next     = PH_DELTA;
          res_emit       = 1'b1;
          res.first_data = b;
        end else begin
          data_hold_next        = b;
          bytes_left_short_next = 2'd1;
          phase_next            = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rs_len == 2'd2 && bytes_left_short_next >= 2'd2) begin
          data_hold_next        = b;
          bytes_left_short_next = 2'd1;
        end else begin
          bytes_left_short_next = '0;
          phase_next            = PH_DELTA;
          res_emit              = 1'b1;
          if (rs_len == 2'd2) begin
            res.first_data  = data_hold;
            res.second_data = b;
          end else begin
            res.first_data = b;
          end
        end
      end
      PH_METATYPE: begin
        meta_kind_next = b;
        vlq_acc_next   = '0;
        phase_next     = PH_LENGTH;
      end
      PH_LENGTH: begin
        vlq_acc_next = {vlq_acc_next[24:0], b[6:0]};
        if (!b[7]) begin
          payload_total_next = vlq_acc_next;
          payload_left_next  = vlq_acc_next;
          vlq_acc_next       = '0;
          payload_seen_next  = '0;
          tempo_acc_next     = '0;
          if (payload_total_next == '0) begin
            phase_next     = PH_DELTA;
            res_emit       = 1'b1;
            res_kind       = KIND_END;
            res.first_data = meta_kind_next;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (payload_seen_next < 2'd3) begin
          tempo_acc_next    = {tempo_acc_next[15:0], b};
          payload_seen_next = payload_seen_next + 2'd1;
        end
        payload_left_next  = payload_left_next - 32'd1;
        res_emit           = 1'b1;
        res.first_data     = meta_kind;
        res.payload_byte   = b;
        res.payload_length = payload_total;
        if (payload_left_next != '0) begin
          res_kind = KIND_PAYLOAD;
        end else begin
          phase_next = PH_DELTA;
          res_kind   = KIND_END;
          tv = running_status == ST_META && meta_kind == META_TEMPO &&
               payload_seen_next == 2'd3 && tempo_enable;
          res.tempo_valid = tv;
          res.tempo_us    = tv ? tempo_acc_next : 24'd0;
        end
      end
      default: begin
        phase_next = PH_DELTA;
      end
    endcase

    // Fields common to every result come from the updated state.
    res.event_status = running_status_next;
    res.delta_ticks  = delta_hold_next;
    res.event_tick   = tick_count_next;
    res.track_index  = track_number_next;
  end

  // Parse state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DELTA;
      running_status   <= '0;
      vlq_acc          <= '0;
      delta_hold       <= '0;
      tick_count       <= '0;
      data_hold        <= '0;
      bytes_left_short <= '0;
      meta_kind        <= '0;
      payload_left     <= '0;
      payload_total    <= '0;
      tempo_acc        <= '0;
      payload_seen     <= '0;
      track_number     <= 8'hFF;
    end else if (accept) begin
      phase            <= phase_next;
      running_status   <= running_status_next;
      vlq_acc          <= vlq_acc_next;
      delta_hold       <= delta_hold_next;
      tick_count       <= tick_count_next;
      data_hold        <= data_hold_next;
      bytes_left_short <= bytes_left_short_next;
      meta_kind        <= meta_kind_next;
      payload_left     <= payload_left_next;
      payload_total    <= payload_total_next;
      tempo_acc        <= tempo_acc_next;
      payload_seen     <= payload_seen_next;
      track_number     <= track_number_next;
    end
  end

  // Tempo report enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      tempo_enable <= cfg_data;
    end
  end

  // Output register; it loads whenever the downstream side can take a new item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= accept && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_emit && s_axis_tready) begin
      out_res  <= res;
      out_kind <= res_kind;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, out_res};
  assign m_axis_tuser = out_kind;

  // A tempo report only rides on the item that ends an event.
  a_tempo_on_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.tempo_valid |-> out_kind == KIND_END)
    else $error("tempo reported on an item that does not end an event");

  // A mid-payload item always belongs to an event with a nonzero length.
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_kind == KIND_PAYLOAD |-> out_res.payload_length != '0)
    else $error("payload item with zero declared length");

  // Inside a payload the parser either stays there or returns to the delta.
  a_payload_exit: assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tuser && phase == PH_PAYLOAD |=>
      phase == PH_PAYLOAD || phase == PH_DELTA)
    else $error("payload phase left to an unexpected phase");

  // An empty output register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire
